### hdl/odq_pkg.sv
// Shared types and codes for the output-restricted deque core.
// No dependencies; imported by odq_ctrl, odq_dpath and output_restricted_deque_core.
package odq_pkg;

   localparam int DEPTH  = 8;
   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] MODE_CLEAR     = 3'd0;
   localparam logic [2:0] MODE_INS_RIGHT = 3'd1;
   localparam logic [2:0] MODE_INS_LEFT  = 3'd2;
   localparam logic [2:0] MODE_REMOVE    = 3'd3;
   localparam logic [2:0] MODE_DUMP      = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OVERFLOW  = 3'd1;
   localparam logic [2:0] ST_UNDERFLOW = 3'd2;
   localparam logic [2:0] ST_ENTRY     = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data_out;
      logic               last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       clear;
      logic       load_right;
      logic       load_left;
      logic       pop;
      logic       dump_start;
      logic       dump_step;
      logic       emit;
      logic [2:0] status;
      logic       read_sel;
      logic       last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last_head;
      logic last_ptr;
   } stat_type;

endpackage

### hdl/output_restricted_deque_core.sv
// Top level of the output-restricted deque core: controller plus datapath.
// Depends on odq_pkg, odq_ctrl and odq_dpath.
//
// A transaction is taken when start is high and busy is low. Every
// transaction produces its first result in the cycle after acceptance,
// on rsp_data, each result flagged by rsp_strobe for exactly one cycle;
// the receiver has no way to stall, so it must take every strobed
// result. Clear, insert-right, insert-left, remove and the unused modes
// can be issued every cycle. A dump of n live entries (n >= 1) emits n
// results back to back, read one per cycle through the entry array's
// single read port; for n > 1, busy is high while the remaining entries
// are read. An empty dump gives one dump-empty result. The final result
// of every transaction carries last = 1. Entries live in a linear array
// of DEPTH words: once the tail reaches the end, both inserts report
// overflow until a clear, even when removes have freed slots at the front.
// No clearing pass runs after reset; the block is ready on the first cycle.
module output_restricted_deque_core
   import odq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: mode decode and dump walk
   odq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // storage, pointers and registered result
   odq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // every accepted transaction yields a result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("no result after accepted transaction");

   // a dump in progress always has a non-final entry on the outputs
   a_dump_flow: assert property (@(posedge clock) disable iff (reset)
      busy |-> (rsp_strobe && !rsp_data.last && rsp_data.status == ST_ENTRY))
      else $error("dump sequence broken");

   // leaving a dump coincides with its final entry
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_data.last))
      else $error("dump ended without final entry");

   // only dumped entries may be non-final
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_ENTRY) |-> rsp_data.last)
      else $error("single-result transaction without last");
`endif

endmodule

### hdl/odq_ctrl.sv
// Controller for the deque core: decodes the transaction mode and sequences dumps.
// Depends on odq_pkg.
module odq_ctrl
   import odq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_data,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic state_ff;
   logic state_in;

   assign busy = (state_ff == S_DUMP);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.emit   = 1'b1;
               cmd.last   = 1'b1;
               cmd.status = ST_OK;
               unique case (req_data.mode)
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  MODE_INS_RIGHT: begin
                     if (stat.full) cmd.status = ST_OVERFLOW;
                     else           cmd.load_right = 1'b1;
                  end
                  MODE_INS_LEFT: begin
                     if (stat.full) cmd.status = ST_OVERFLOW;
                     else           cmd.load_left = 1'b1;
                  end
                  MODE_REMOVE: begin
                     if (stat.empty) begin
                        cmd.status = ST_UNDERFLOW;
                     end else begin
                        cmd.pop      = 1'b1;
                        cmd.read_sel = 1'b1;
                     end
                  end
                  MODE_DUMP: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.dump_start = 1'b1;
                        cmd.read_sel   = 1'b1;
                        cmd.status     = ST_ENTRY;
                        cmd.last       = stat.last_head;
                        if (!stat.last_head) state_in = S_DUMP;
                     end
                  end
                  default: begin
                     // unused modes: plain ok, no state change
                  end
               endcase
            end
         end
         S_DUMP: begin
            cmd.emit      = 1'b1;
            cmd.dump_step = 1'b1;
            cmd.read_sel  = 1'b1;
            cmd.status    = ST_ENTRY;
            cmd.last      = stat.last_ptr;
            if (stat.last_ptr) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hdl/odq_dpath.sv
// Datapath for the deque core: entry array, head/tail/dump pointers, result register.
// Depends on odq_pkg; driven by odq_ctrl.
module odq_dpath
   import odq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   logic signed [31:0] entries_ff [DEPTH];
   logic signed [31:0] entries_in [DEPTH];
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   rd_idx;
   logic signed [31:0] rd_word;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff, rsp_in;

   assign stat.empty     = (head_ff == tail_ff);
   assign stat.full      = (tail_ff == IDX_W'(DEPTH));
   assign stat.last_head = ((head_ff + IDX_W'(1)) == tail_ff);
   assign stat.last_ptr  = ((ptr_ff + IDX_W'(1)) == tail_ff);

   // single read port: head for remove and first dump entry, ptr afterwards
   assign rd_idx  = cmd.dump_step ? ptr_ff : head_ff;
   assign rd_word = entries_ff[rd_idx[ADDR_W-1:0]];

   // shift chain: insert-left moves head..tail-1 up one slot
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (cmd.load_right && (tail_ff == IDX_W'(i))) begin
            entries_in[i] = req_data.value;
         end else if (cmd.load_left) begin
            if (head_ff == IDX_W'(i))
               entries_in[i] = req_data.value;
            else if ((IDX_W'(i) > head_ff) && (IDX_W'(i) <= tail_ff))
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      ptr_in  = ptr_ff;
      if (cmd.clear) begin
         head_in = '0;
         tail_in = '0;
      end
      if (cmd.load_right || cmd.load_left) tail_in = tail_ff + IDX_W'(1);
      if (cmd.pop)        head_in = head_ff + IDX_W'(1);
      if (cmd.dump_start) ptr_in  = head_ff + IDX_W'(1);
      if (cmd.dump_step)  ptr_in  = ptr_ff + IDX_W'(1);
   end

   always_comb begin
      rsp_in.status   = cmd.status;
      rsp_in.data_out = cmd.read_sel ? rd_word : 32'sd0;
      rsp_in.last     = cmd.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
      for (int i = 0; i < DEPTH; i++) entries_ff[i] <= entries_in[i];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
